[rtl/core/erv_pkg.sv]
// Package: shared types and constants for the Euler rotation datapath.
`timescale 1ns / 1ps
package erv_pkg;

  // CORDIC setup
  localparam int Steps     = 28;
  localparam int CoefFrac  = 30;
  localparam int CoefBits  = 34;   // signed Q2.30 with headroom
  localparam int ResBits   = 32;   // residual angle
  localparam int PhaseBits = 32;

  localparam logic signed [CoefBits-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CoefBits-1:0] CoefOne    = 34'sd1073741824;

  // quadrant codes
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // state handed from one CORDIC cell to the next
  typedef struct packed {
    logic signed [CoefBits-1:0] x;
    logic signed [CoefBits-1:0] y;
    logic signed [ResBits-1:0]  z;
    quad_t                      quad;
    logic                       exact;   // angle is a whole quadrant
  } cordic_t;

  // arctangent of 2^-i in phase units (2^32 per turn)
  function automatic logic signed [ResBits-1:0] atan_turn(input logic [4:0] i);
    logic signed [ResBits-1:0] r;
    begin
      case (i)
        5'd0:  r = 32'sd536870912;
        5'd1:  r = 32'sd316933406;
        5'd2:  r = 32'sd167458907;
        5'd3:  r = 32'sd85004756;
        5'd4:  r = 32'sd42667331;
        5'd5:  r = 32'sd21354465;
        5'd6:  r = 32'sd10679838;
        5'd7:  r = 32'sd5340245;
        5'd8:  r = 32'sd2670163;
        5'd9:  r = 32'sd1335087;
        5'd10: r = 32'sd667544;
        5'd11: r = 32'sd333772;
        5'd12: r = 32'sd166886;
        5'd13: r = 32'sd83443;
        5'd14: r = 32'sd41722;
        5'd15: r = 32'sd20861;
        5'd16: r = 32'sd10430;
        5'd17: r = 32'sd5215;
        5'd18: r = 32'sd2608;
        5'd19: r = 32'sd1304;
        5'd20: r = 32'sd652;
        5'd21: r = 32'sd326;
        5'd22: r = 32'sd163;
        5'd23: r = 32'sd81;
        5'd24: r = 32'sd41;
        5'd25: r = 32'sd20;
        5'd26: r = 32'sd10;
        5'd27: r = 32'sd5;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/core/erv_if.sv]
// Interfaces: input vector/angle channel and output vector channel.
`timescale 1ns / 1ps
interface erv_in_if #(
  parameter int VALUE_BITS = 32,
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] vec_x;
  logic signed [VALUE_BITS-1:0] vec_y;
  logic signed [VALUE_BITS-1:0] vec_z;
  logic [ANGLE_BITS-1:0]        roll_angle;
  logic [ANGLE_BITS-1:0]        pitch_angle;
  logic [ANGLE_BITS-1:0]        yaw_angle;

  modport source (output valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
                output ready);
endinterface

interface erv_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] out_x;
  logic signed [VALUE_BITS-1:0] out_y;
  logic signed [VALUE_BITS-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

[rtl/core/erv_cordic_cell.sv]
// One CORDIC micro-rotation cell of the sine/cosine chain.
`timescale 1ns / 1ps
module erv_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  erv_pkg::cordic_t din,
  output erv_pkg::cordic_t dout
);

  localparam logic [4:0] StepIdx = 5'(STEP);

  erv_pkg::cordic_t nxt;

  // rotate toward zero residual angle
  always_comb begin
    nxt = din;
    if (!din.z[erv_pkg::ResBits-1]) begin
      nxt.x = din.x - (din.y >>> STEP);
      nxt.y = din.y + (din.x >>> STEP);
      nxt.z = din.z - erv_pkg::atan_turn(StepIdx);
    end else begin
      nxt.x = din.x + (din.y >>> STEP);
      nxt.y = din.y - (din.x >>> STEP);
      nxt.z = din.z + erv_pkg::atan_turn(StepIdx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/core/erv_rot_stage.sv]
// Planar rotation of one component pair: products, then round and saturate.
`timescale 1ns / 1ps
module erv_rot_stage #(
  parameter int VALUE_BITS = 32,
  parameter int PASS_BITS  = 1
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [VALUE_BITS-1:0]          a,
  input  logic signed [VALUE_BITS-1:0]          b,
  input  logic signed [erv_pkg::CoefBits-1:0]   c,
  input  logic signed [erv_pkg::CoefBits-1:0]   s,
  input  logic [PASS_BITS-1:0]                  pass_in,
  output logic signed [VALUE_BITS-1:0]          na,
  output logic signed [VALUE_BITS-1:0]          nb,
  output logic [PASS_BITS-1:0]                  pass_out
);

  localparam int PW = VALUE_BITS + erv_pkg::CoefBits;
  localparam int SW = PW + 1;
  localparam int RW = SW - erv_pkg::CoefFrac;

  logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;
  logic [PASS_BITS-1:0] pass_mid;
  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [RW-1:0] rnd_a, rnd_b;
  logic signed [VALUE_BITS-1:0] sat_a, sat_b;

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      p_ac     <= PW'(a) * PW'(c);
      p_bs     <= PW'(b) * PW'(s);
      p_as     <= PW'(a) * PW'(s);
      p_bc     <= PW'(b) * PW'(c);
      pass_mid <= pass_in;
    end
  end

  // round half up, drop fraction bits, clamp
  function automatic logic signed [VALUE_BITS-1:0] clamp(input logic signed [RW-1:0] v);
    logic signed [VALUE_BITS-1:0] r;
    begin
      if (v > RW'(signed'({1'b0, {(VALUE_BITS-1){1'b1}}})))
        r = {1'b0, {(VALUE_BITS-1){1'b1}}};
      else if (v < RW'(signed'({1'b1, {(VALUE_BITS-1){1'b0}}})))
        r = {1'b1, {(VALUE_BITS-1){1'b0}}};
      else
        r = v[VALUE_BITS-1:0];
      return r;
    end
  endfunction

  always_comb begin
    sum_a = SW'(p_ac) - SW'(p_bs) + (SW'(1) <<< (erv_pkg::CoefFrac - 1));
    sum_b = SW'(p_as) + SW'(p_bc) + (SW'(1) <<< (erv_pkg::CoefFrac - 1));
    rnd_a = RW'(sum_a >>> erv_pkg::CoefFrac);
    rnd_b = RW'(sum_b >>> erv_pkg::CoefFrac);
    sat_a = clamp(rnd_a);
    sat_b = clamp(rnd_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na       <= sat_a;
      nb       <= sat_b;
      pass_out <= pass_mid;
    end
  end

endmodule

[rtl/core/euler_rotate_vector3.sv]
// Top level: roll/pitch/yaw rotation of a fixed-point 3D vector.
//
//  channel | dir | payload                                        | handshake
//  vin     | in  | vec_x/y/z, roll_angle, pitch_angle, yaw_angle  | valid/ready
//  vout    | out | out_x/y/z                                      | valid/ready
//
// One transfer per cycle in and out while the pipeline advances; data goes
// through 28 CORDIC cells, one quadrant map, then the roll, pitch and yaw stages.
// The whole pipeline advances together; it holds when the output is full
// and not taken, and vin.ready is low only then.
// Reset (rst, synchronous) clears the valid bits only.
`timescale 1ns / 1ps
module euler_rotate_vector3 #(
  parameter int VALUE_BITS = 32,
  parameter int ANGLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  erv_in_if.sink    vin,
  erv_out_if.source vout
);

  localparam int N   = erv_pkg::Steps;
  localparam int LAT = N + 7;
  localparam int CW  = erv_pkg::CoefBits;
  localparam int VB  = VALUE_BITS;

  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !vld[LAT-1] || vout.ready;
  assign vin.ready = adv;

  // valid bits move with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], vin.valid};
    end
  end

  // seed the three CORDIC chains from the angles
  function automatic erv_pkg::cordic_t seed(input logic [ANGLE_BITS-1:0] ang);
    logic [erv_pkg::PhaseBits-1:0] ph;
    erv_pkg::cordic_t r;
    begin
      ph      = {ang, {(erv_pkg::PhaseBits-ANGLE_BITS){1'b0}}};
      r.x     = erv_pkg::CordicGain;
      r.y     = '0;
      r.z     = erv_pkg::ResBits'({2'b00, ph[erv_pkg::PhaseBits-3:0]});
      r.quad  = erv_pkg::quad_t'(ph[erv_pkg::PhaseBits-1 -: 2]);
      r.exact = (ph[erv_pkg::PhaseBits-3:0] == '0);
      return r;
    end
  endfunction

  erv_pkg::cordic_t chain [3][N+1];

  assign chain[0][0] = seed(vin.roll_angle);
  assign chain[1][0] = seed(vin.pitch_angle);
  assign chain[2][0] = seed(vin.yaw_angle);

  for (genvar a = 0; a < 3; a++) begin : g_ang
    for (genvar i = 0; i < N; i++) begin : g_cell
      erv_cordic_cell #(.STEP(i)) u_cell (
        .clk (clk),
        .en  (adv),
        .din (chain[a][i]),
        .dout(chain[a][i+1])
      );
    end
  end

  // vector rides alongside the CORDIC chain
  logic signed [VB-1:0] dx [N+1];
  logic signed [VB-1:0] dy [N+1];
  logic signed [VB-1:0] dz [N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dx[0] <= vin.vec_x;
      dy[0] <= vin.vec_y;
      dz[0] <= vin.vec_z;
      for (int k = 1; k <= N; k++) begin
        dx[k] <= dx[k-1];
        dy[k] <= dy[k-1];
        dz[k] <= dz[k-1];
      end
    end
  end

  // quadrant map to (cos, sin)
  logic signed [CW-1:0] cc [3];
  logic signed [CW-1:0] ss [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [CW-1:0] ux, uy;
        ux = chain[a][N].exact ? erv_pkg::CoefOne : chain[a][N].x;
        uy = chain[a][N].exact ? '0 : chain[a][N].y;
        unique case (chain[a][N].quad)
          erv_pkg::QUAD_0: begin cc[a] <= ux;  ss[a] <= uy;  end
          erv_pkg::QUAD_1: begin cc[a] <= -uy; ss[a] <= ux;  end
          erv_pkg::QUAD_2: begin cc[a] <= -ux; ss[a] <= -uy; end
          erv_pkg::QUAD_3: begin cc[a] <= uy;  ss[a] <= -ux; end
          default:         begin cc[a] <= ux;  ss[a] <= uy;  end
        endcase
      end
    end
  end

  // roll: (y, z), carrying x and the pitch/yaw coefficients
  localparam int P1 = VB + 4 * CW;
  logic signed [VB-1:0] r_y, r_z;
  logic [P1-1:0]        r_pass;

  erv_rot_stage #(.VALUE_BITS(VB), .PASS_BITS(P1)) u_roll (
    .clk(clk), .en(adv), .a(dy[N]), .b(dz[N]), .c(cc[0]), .s(ss[0]),
    .pass_in({dx[N], cc[1], ss[1], cc[2], ss[2]}),
    .na(r_y), .nb(r_z), .pass_out(r_pass)
  );

  // pitch: (z, x)
  localparam int P2 = VB + 2 * CW;
  logic signed [VB-1:0] p_z, p_x;
  logic [P2-1:0]        p_pass;

  erv_rot_stage #(.VALUE_BITS(VB), .PASS_BITS(P2)) u_pitch (
    .clk(clk), .en(adv), .a(r_z), .b(r_pass[P1-1 -: VB]),
    .c(r_pass[4*CW-1 -: CW]), .s(r_pass[3*CW-1 -: CW]),
    .pass_in({r_y, r_pass[2*CW-1:0]}),
    .na(p_z), .nb(p_x), .pass_out(p_pass)
  );

  // yaw: (x, y)
  erv_rot_stage #(.VALUE_BITS(VB), .PASS_BITS(VB)) u_yaw (
    .clk(clk), .en(adv), .a(p_x), .b(p_pass[P2-1 -: VB]),
    .c(p_pass[2*CW-1 -: CW]), .s(p_pass[CW-1:0]),
    .pass_in(p_z),
    .na(vout.out_x), .nb(vout.out_y), .pass_out(vout.out_z)
  );

  assign vout.valid = vld[LAT-1];

  // checks
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (rst)
    vout.valid && !vout.ready |-> !vin.ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    vin.valid && vin.ready |=> vld[0])
    else $error("accepted transfer lost at pipeline entry");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vout.valid)
    else $error("output valid after reset");

endmodule

[tb/sv/erv_rotation_checker.sv]
// Checker: watches the vector channels, predicts rotated vectors and compares them.
`timescale 1ns / 1ps
module erv_rotation_checker #(
  parameter int VALUE_BITS = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  erv_in_if    vin,
  erv_out_if   vout,
  output int   fail_count,
  output int   pending_count
);

  typedef struct {
    logic signed [VALUE_BITS-1:0] x;
    logic signed [VALUE_BITS-1:0] y;
    logic signed [VALUE_BITS-1:0] z;
  } vec3_t;

  vec3_t rotated_q[$];

  // sine/cosine of a binary angle, Q2.30
  function automatic void angle_trig(input logic [ANGLE_BITS-1:0] ang,
                                     output longint c, output longint s);
    logic [31:0]     ph;
    erv_pkg::quad_t  q;
    longint          x, y, z, dx, dy;
    begin
      ph = 32'(ang) << (32 - ANGLE_BITS);
      q  = erv_pkg::quad_t'(ph[31:30]);
      z  = longint'(ph[29:0]);
      x  = longint'(erv_pkg::CordicGain);
      y  = 0;
      if (z == 0) begin
        x = longint'(erv_pkg::CoefOne);
      end else begin
        for (int i = 0; i < erv_pkg::Steps; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(erv_pkg::atan_turn(5'(i)));
          end else begin
            x += dx; y -= dy; z += longint'(erv_pkg::atan_turn(5'(i)));
          end
        end
      end
      case (q)
        erv_pkg::QUAD_0: begin c = x;  s = y;  end
        erv_pkg::QUAD_1: begin c = -y; s = x;  end
        erv_pkg::QUAD_2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    end
  endfunction

  // round half up, drop 30 fraction bits, clamp to the component range
  function automatic logic signed [VALUE_BITS-1:0] round_sat(logic signed [127:0] acc);
    logic signed [127:0] r, mx, mn;
    begin
      r  = (acc + (128'sd1 <<< (erv_pkg::CoefFrac - 1))) >>> erv_pkg::CoefFrac;
      mx = (128'sd1 <<< (VALUE_BITS - 1)) - 1;
      mn = -(128'sd1 <<< (VALUE_BITS - 1));
      if (r > mx) r = mx;
      if (r < mn) r = mn;
      return r[VALUE_BITS-1:0];
    end
  endfunction

  function automatic void plane_turn(inout logic signed [VALUE_BITS-1:0] a,
                                     inout logic signed [VALUE_BITS-1:0] b,
                                     input logic [ANGLE_BITS-1:0] ang);
    longint c, s;
    logic signed [127:0] aw, bw, cw, sw;
    begin
      angle_trig(ang, c, s);
      aw = a; bw = b; cw = c; sw = s;
      a = round_sat(aw * cw - bw * sw);
      b = round_sat(aw * sw + bw * cw);
    end
  endfunction

  function automatic vec3_t rotate_euler(vec3_t v, logic [ANGLE_BITS-1:0] roll,
                                         logic [ANGLE_BITS-1:0] pitch,
                                         logic [ANGLE_BITS-1:0] yaw);
    begin
      plane_turn(v.y, v.z, roll);
      plane_turn(v.z, v.x, pitch);
      plane_turn(v.x, v.y, yaw);
      return v;
    end
  endfunction

  assign pending_count = rotated_q.size();

  always @(posedge clk) begin
    vec3_t v, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      // prediction on input transfer
      if (vin.valid && vin.ready) begin
        v.x = vin.vec_x; v.y = vin.vec_y; v.z = vin.vec_z;
        rotated_q.push_back(rotate_euler(v, vin.roll_angle, vin.pitch_angle,
                                         vin.yaw_angle));
      end
      // compare on output transfer
      if (vout.valid && vout.ready) begin
        if (rotated_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected output %h %h %h", $time,
                     vout.out_x, vout.out_y, vout.out_z);
          fail_count <= fail_count + 1;
        end else begin
          v = rotated_q.pop_front();
          got.x = vout.out_x; got.y = vout.out_y; got.z = vout.out_z;
          if (got.x !== v.x || got.y !== v.y || got.z !== v.z) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp %h %h %h got %h %h %h", $time,
                       v.x, v.y, v.z, got.x, got.y, got.z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sv/euler_rotate_vector3_tb.sv]
// Testbench top: drives vectors and angles into the rotator and reports the verdict.
`timescale 1ns / 1ps
module euler_rotate_vector3_tb;
  localparam int VALUE_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CALM_TAIL = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count;
  bit   idle_enable = 1'b1;

  erv_in_if  #(.VALUE_BITS(VALUE_BITS), .ANGLE_BITS(ANGLE_BITS)) vin ();
  erv_out_if #(.VALUE_BITS(VALUE_BITS)) vout ();

  euler_rotate_vector3 #(.VALUE_BITS(VALUE_BITS), .ANGLE_BITS(ANGLE_BITS)) dut (
    .clk(clk), .rst(rst), .vin(vin), .vout(vout)
  );

  erv_rotation_checker #(.VALUE_BITS(VALUE_BITS), .ANGLE_BITS(ANGLE_BITS)) checker_i (
    .clk(clk), .rst(rst), .vin(vin), .vout(vout),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin
    #3ms;
    $display("euler_rotate_vector3 test failed");
    $finish;
  end

  // output side backpressure in bursts
  initial begin
    int n;
    vout.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        vout.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        vout.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
      1: return ANGLE_BITS'($urandom_range(0, 3));
      default: return ANGLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_vector(input logic [31:0] x, y, z,
                             input logic [ANGLE_BITS-1:0] r, p, w);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      vin.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    vin.valid <= 1'b1;
    vin.vec_x <= x; vin.vec_y <= y; vin.vec_z <= z;
    vin.roll_angle <= r; vin.pitch_angle <= p; vin.yaw_angle <= w;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] big;
    vin.valid = 1'b0;
    vin.vec_x = '0; vin.vec_y = '0; vin.vec_z = '0;
    vin.roll_angle = '0; vin.pitch_angle = '0; vin.yaw_angle = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: zero angles, quadrant angles, extremes, saturation
    send_vector(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 0, 0, 0);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send_vector(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000, 0, 0);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 16'h4000, 0);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 16'h4000);
    send_vector(32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 16'h8000, 16'h8000, 16'h8000);
    send_vector(32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 16'hC000, 16'hC000, 16'hC000);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 0, 0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h6000, 16'hA000, 16'hE000);
    send_vector(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0001, 16'h0001, 16'h0001);
    send_vector(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 16'h5555, 16'hAAAA, 16'h1234);
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h8001, 16'h3FFF);

    // drain once with the sender held off
    vin.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);

    // random vectors; quiet tail with no idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_TAIL) idle_enable = 1'b0;
      big = pick_component();
      send_vector(big, pick_component(), pick_component(),
                  pick_angle(), pick_angle(), pick_angle());
    end
    vin.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("euler_rotate_vector3 test passed");
    else
      $display("euler_rotate_vector3 test failed");
    $finish;
  end
endmodule
